// ----- hdl/sfr_pkg.sv -----
package sfr_pkg;

   // sizes of the pattern window and the replacement
   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;

   // depth of the queue between the front and back ends
   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam logic [2:0] CSR_PATTERN_BYTES     = 3'd0;
   localparam logic [2:0] CSR_PATTERN_LEN       = 3'd1;
   localparam logic [2:0] CSR_REPLACEMENT_BYTES = 3'd2;
   localparam logic [2:0] CSR_REPLACEMENT_LEN   = 3'd3;
   localparam logic [2:0] CSR_OUT_LIMIT         = 3'd4;

   // input word
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic       overflow;
   } rsp_type;

   // one classified input word: up to eight bytes to emit, plus end flags
   typedef struct packed {
      logic [63:0] bytes;
      logic [3:0]  count;
      logic        last;
      logic        ovf;
   } entry_type;

endpackage

// ----- hdl/sfr_front.sv -----
module sfr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sfr_pkg::req_type   req_data,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data,
   input  logic               queue_full,
   output logic               push,
   output sfr_pkg::entry_type push_entry
);

   // configuration registers
   logic [63:0] pattern_ff;
   logic [3:0]  pattern_len_ff;
   logic [63:0] replacement_ff;
   logic [3:0]  replacement_len_ff;
   logic [15:0] out_limit_ff;

   // window and stream state
   logic [7:0]  win_ff [0:7];
   logic [2:0]  wcount_ff;
   logic [15:0] produced_ff;
   logic        ovf_seen_ff;

   logic        accept;
   logic [7:0]  new_win [0:7];
   logic [3:0]  fill;
   logic        full;
   logic        match;
   logic [3:0]  gen;
   logic [63:0] vec;
   logic [15:0] room;
   logic        drop;
   logic [3:0]  kept;
   logic [3:0]  wr_len;
   logic [3:0]  wr_rlen;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // saturate written lengths
   always_comb begin
      wr_len = csr_data[3:0];
      if (wr_len == 4'd0) begin
         wr_len = 4'd1;
      end else if (wr_len > 4'(sfr_pkg::MAX_PATTERN)) begin
         wr_len = 4'(sfr_pkg::MAX_PATTERN);
      end
      wr_rlen = csr_data[3:0];
      if (wr_rlen > 4'(sfr_pkg::MAX_REPLACEMENT)) begin
         wr_rlen = 4'(sfr_pkg::MAX_REPLACEMENT);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff         <= '0;
         pattern_len_ff     <= 4'd1;
         replacement_ff     <= '0;
         replacement_len_ff <= '0;
         out_limit_ff       <= 16'hffff;
      end else if (csr_valid) begin
         case (csr_index)
            sfr_pkg::CSR_PATTERN_BYTES: begin
               pattern_ff <= csr_data;
            end
            sfr_pkg::CSR_PATTERN_LEN: begin
               if (wcount_ff == 3'd0) begin
                  pattern_len_ff <= wr_len;
               end
            end
            sfr_pkg::CSR_REPLACEMENT_BYTES: begin
               replacement_ff <= csr_data;
            end
            sfr_pkg::CSR_REPLACEMENT_LEN: begin
               replacement_len_ff <= wr_rlen;
            end
            sfr_pkg::CSR_OUT_LIMIT: begin
               out_limit_ff <= csr_data[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   // window with the new byte written in, and the pattern compare
   always_comb begin
      match = 1'b1;
      vec   = '0;
      for (int i = 0; i < 8; i++) begin
         new_win[i] = (3'(i) == wcount_ff) ? req_data.in_byte : win_ff[i];
         vec[8*i +: 8] = new_win[i];
         if ((4'(i) < pattern_len_ff) && (new_win[i] != pattern_ff[8*i +: 8])) begin
            match = 1'b0;
         end
      end
   end

   assign fill = {1'b0, wcount_ff} + 4'd1;
   assign full = (fill == pattern_len_ff);

   // bytes this word generates
   always_comb begin
      gen = 4'd0;
      if (full && match) begin
         gen = replacement_len_ff;
      end else if (req_data.in_last) begin
         gen = fill;
      end else if (full) begin
         gen = 4'd1;
      end
   end

   // output limit
   assign room = (produced_ff < out_limit_ff) ? (out_limit_ff - produced_ff) : 16'd0;
   assign drop = ({12'd0, gen} > room);
   assign kept = drop ? room[3:0] : gen;

   // word for the back end
   always_comb begin
      push_entry.bytes = (full && match) ? replacement_ff : vec;
      push_entry.count = kept;
      push_entry.last  = req_data.in_last;
      push_entry.ovf   = ovf_seen_ff || drop;
   end
   assign push = accept && ((kept != 4'd0) || req_data.in_last);

   // stream state update
   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff   <= '0;
         produced_ff <= '0;
         ovf_seen_ff <= 1'b0;
      end else if (accept) begin
         if (req_data.in_last) begin
            produced_ff <= '0;
            ovf_seen_ff <= 1'b0;
         end else begin
            produced_ff <= produced_ff + {12'd0, kept};
            ovf_seen_ff <= ovf_seen_ff || drop;
         end
         if ((full && match) || req_data.in_last) begin
            wcount_ff <= '0;
         end else if (full) begin
            wcount_ff <= 3'(pattern_len_ff - 4'd1);
         end else begin
            wcount_ff <= fill[2:0];
         end
      end
   end

   // window bytes, shifted by one when the oldest byte leaves
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 8; i++) begin
            if (full && !match && (i < 7)) begin
               win_ff[i] <= new_win[i+1];
            end else begin
               win_ff[i] <= new_win[i];
            end
         end
      end
   end

endmodule

// ----- hdl/sfr_queue.sv -----
module sfr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sfr_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output sfr_pkg::entry_type head
);

   localparam int PtrW = $clog2(sfr_pkg::QUEUE_DEPTH);

   sfr_pkg::entry_type entries_ff [0:sfr_pkg::QUEUE_DEPTH-1];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW:0]   count_ff;

   assign full       = (count_ff == (PtrW+1)'(sfr_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hdl/sfr_back.sv -----
module sfr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  sfr_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sfr_pkg::rsp_type   rsp_data
);

   logic [2:0]       idx_ff;
   logic             rsp_valid_ff;
   sfr_pkg::rsp_type rsp_data_ff;
   logic             load;
   logic             is_final;
   logic             empty_word;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign empty_word = (head.count == 4'd0);
   assign is_final   = empty_word || ({1'b0, idx_ff} == head.count - 4'd1);
   assign load       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop        = load && is_final;

   // byte index within the current word
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (load) begin
         idx_ff <= is_final ? 3'd0 : idx_ff + 3'd1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff.out_byte  <= empty_word ? 8'd0 : head.bytes[{idx_ff, 3'b000} +: 8];
         rsp_data_ff.out_valid <= !empty_word;
         rsp_data_ff.out_last  <= head.last && is_final;
         rsp_data_ff.overflow  <= head.last && is_final && head.ovf;
      end
   end

endmodule

// ----- hdl/stream_find_replace_top.sv -----
// Streaming find and replace: every leftmost, non-overlapping occurrence of the
// configured pattern (1 to 8 bytes) is replaced by the configured replacement
// (0 to 8 bytes), other bytes pass through, and the final word of a stream
// carries out_last and the overflow flag once out_limit bytes were exceeded.
// An input word is taken every cycle while the four-entry queue has room; the
// front end classifies it in that cycle. The back end sends one result word
// per cycle while the queue holds a word and rsp_ready does not hold it off.
// An input word produces one result word for a plain byte, up to eight for a
// replacement or an end flush, one for a bare end marker, and a word that
// produces nothing is not queued. Result words pass through the queue entry
// and the back end's output register. Configuration writes are taken every
// cycle; the pattern length only while the window is empty.
module stream_find_replace_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sfr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sfr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_data
);

   logic               push;
   sfr_pkg::entry_type push_entry;
   logic               queue_full;
   logic               pop;
   logic               head_valid;
   sfr_pkg::entry_type head;

   assign csr_ready = 1'b1;

   // classify input words
   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // serialize into result words
   sfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // no push into a full queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("push into full queue");

   // pop only when the queue holds a word
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   // an end marker without a byte is always the final word
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.out_valid) |-> rsp_data.out_last)
      else $error("end marker not last");

   // overflow is only reported on the final word
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |-> rsp_data.out_last)
      else $error("overflow on non-final word");

endmodule

// ----- sim/stream_find_replace_top_tb.sv -----
`timescale 1ns / 1ps

module stream_find_replace_top_tb;

   localparam int     HALF_PERIOD  = 2;
   localparam int     RESET_CYCLES = 12;
   localparam int     SETTLE_WAIT  = 16;
   localparam int     LONG_HOLD    = 80;
   localparam int     RANDOM_ITEMS = 200;
   localparam int     PHASE_ITEMS  = 30;
   localparam int     MAX_REPORTS  = 40;
   localparam longint RUN_LIMIT_NS = 4_000_000;

   typedef logic [7:0] byte_queue_type[$];

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sfr_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sfr_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_index = '0;
   logic [63:0]      csr_data  = '0;

   // register shadow, at reset values
   logic [63:0] pat_bytes  = '0;
   int          pat_len    = 1;
   logic [63:0] rep_bytes  = '0;
   int          rep_len    = 0;
   int          byte_limit = 65535;

   // find/replace state of the shadow model
   logic [7:0]  win_bytes [sfr_pkg::MAX_PATTERN];
   int          win_fill   = 0;
   int          bytes_sent = 0;
   logic        limit_hit  = 1'b0;

   sfr_pkg::rsp_type expected_words[$];
   logic [7:0]       step_out[$];
   sfr_pkg::rsp_type oldest;
   int               mismatches  = 0;
   logic             no_idling   = 1'b0;
   logic             hold_output = 1'b0;
   logic [7:0]       letter_a    = 8'h61;
   logic [7:0]       letter_b    = 8'h62;

   stream_find_replace_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_REPORTS) begin
         $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   // one output byte, dropped once the stream limit is used up
   function automatic void emit_byte(input logic [7:0] b);
      if (bytes_sent < byte_limit) begin
         step_out.push_back(b);
         bytes_sent++;
      end else begin
         limit_hit = 1'b1;
      end
   endfunction

   // advance the find/replace state by one input word, queue its result words
   function automatic void predict_word(input logic [7:0] b, input logic last);
      int   i;
      int   n;
      logic hit;
      logic fin;
      step_out.delete();
      if (win_fill >= pat_len) win_fill = pat_len - 1;
      win_bytes[win_fill] = b;
      win_fill++;
      if (win_fill == pat_len) begin
         hit = 1'b1;
         for (i = 0; i < pat_len; i++) begin
            if (win_bytes[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
         end
         if (hit) begin
            for (i = 0; i < rep_len; i++) emit_byte(rep_bytes[8*i +: 8]);
            win_fill = 0;
         end else begin
            emit_byte(win_bytes[0]);
            for (i = 1; i < win_fill; i++) win_bytes[i-1] = win_bytes[i];
            win_fill--;
         end
      end
      // end of stream: flush what is left in the window
      if (last) begin
         for (i = 0; i < win_fill; i++) emit_byte(win_bytes[i]);
         win_fill = 0;
         if (step_out.size() == 0) begin
            expected_words.push_back('{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1,
                                       overflow: limit_hit});
         end
      end
      n = step_out.size();
      for (i = 0; i < n; i++) begin
         fin = last && (i == n - 1);
         expected_words.push_back('{out_byte: step_out[i], out_valid: 1'b1, out_last: fin,
                                    overflow: fin & limit_hit});
      end
      if (last) begin
         bytes_sent = 0;
         limit_hit  = 1'b0;
      end
   endfunction

   // register write as the block applies it
   function automatic void predict_csr(input logic [2:0] idx, input logic [63:0] val);
      case (idx)
         sfr_pkg::CSR_PATTERN_BYTES: pat_bytes = val;
         sfr_pkg::CSR_PATTERN_LEN: begin
            if (win_fill == 0) begin
               if (val[3:0] == 4'd0) pat_len = 1;
               else if (int'(val[3:0]) > sfr_pkg::MAX_PATTERN) pat_len = sfr_pkg::MAX_PATTERN;
               else pat_len = int'(val[3:0]);
            end
         end
         sfr_pkg::CSR_REPLACEMENT_BYTES: rep_bytes = val;
         sfr_pkg::CSR_REPLACEMENT_LEN: begin
            if (int'(val[3:0]) > sfr_pkg::MAX_REPLACEMENT) rep_len = sfr_pkg::MAX_REPLACEMENT;
            else rep_len = int'(val[3:0]);
         end
         sfr_pkg::CSR_OUT_LIMIT: byte_limit = int'(val[15:0]);
         default: ;
      endcase
   endfunction

   // offer one input word; returns at the falling edge after it is taken
   task automatic send_word(input logic [7:0] b, input logic last);
      if (!no_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, in_last: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(b, last);
      @(negedge clock);
   endtask

   task automatic send_text(input byte_queue_type text);
      int i;
      for (i = 0; i < text.size(); i++) send_word(text[i], i == text.size() - 1);
   endtask

   // register write; csr_valid stays up for back-to-back writes
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      predict_csr(idx, val);
      @(negedge clock);
   endtask

   // all five registers, with junk above the used bits
   task automatic configure(input logic [63:0] pattern_value, input int plen,
                            input logic [63:0] repl_value, input int rlen, input int limit);
      write_reg(sfr_pkg::CSR_PATTERN_BYTES, pattern_value);
      write_reg(sfr_pkg::CSR_PATTERN_LEN, {$urandom, 28'($urandom), 4'(plen)});
      write_reg(sfr_pkg::CSR_REPLACEMENT_BYTES, repl_value);
      write_reg(sfr_pkg::CSR_REPLACEMENT_LEN, {$urandom, 28'($urandom), 4'(rlen)});
      write_reg(sfr_pkg::CSR_OUT_LIMIT, {$urandom, 16'($urandom), 16'(limit)});
      csr_valid <= 1'b0;
   endtask

   // stop sending, wait for every expected word, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   // text built mostly from whole patterns and pattern letters
   function automatic byte_queue_type make_text(input int goal);
      byte_queue_type text;
      int             i;
      while (text.size() < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               for (i = 0; i < pat_len; i++) text.push_back(pat_bytes[8*i +: 8]);
            end
            3, 4, 5, 6: text.push_back($urandom_range(0, 1) ? letter_a : letter_b);
            default: text.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      return text;
   endfunction

   task automatic random_config(input int phase);
      logic [63:0] pattern_value;
      int          plen;
      int          rlen;
      int          limit;
      int          i;
      letter_a = 8'($urandom_range(0, 255));
      letter_b = 8'($urandom_range(0, 255));
      for (i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
         pattern_value[8*i +: 8] = $urandom_range(0, 1) ? letter_a : letter_b;
      end
      case (phase % 4)
         0: plen = sfr_pkg::MAX_PATTERN;
         1: plen = 1;
         default: plen = $urandom_range(1, sfr_pkg::MAX_PATTERN);
      endcase
      case (phase % 3)
         0: rlen = sfr_pkg::MAX_REPLACEMENT;
         1: rlen = 0;
         default: rlen = $urandom_range(0, sfr_pkg::MAX_REPLACEMENT);
      endcase
      if (phase == 2) limit = 0;
      else if (phase % 3 == 0) limit = $urandom_range(1, 12);
      else if (phase % 5 == 4) limit = $urandom_range(0, 65535);
      else limit = 65535;
      configure(pattern_value, plen, {$urandom, $urandom}, rlen, limit);
   endtask

   // reset registers: a single zero byte is deleted
   task automatic test_defaults();
      send_word(8'h00, 1'b1);
      send_word(8'h41, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      settle();
   endtask

   // leftmost non-overlapping matches, partial match flushed, longest pattern
   task automatic test_matching();
      byte_queue_type text;
      int             i;
      configure(64'h0000_0000_0061_6261, 3, 64'h5958, 2, 65535);
      text = {8'h61, 8'h62, 8'h61, 8'h62, 8'h61, 8'h62, 8'h78};
      send_text(text);
      settle();
      configure(64'h00FF_FF00_FF00_00FF, sfr_pkg::MAX_PATTERN, 64'hFF00_00FF_00FF_FF00,
                sfr_pkg::MAX_REPLACEMENT, 65535);
      text.delete();
      for (i = 0; i < sfr_pkg::MAX_PATTERN; i++) text.push_back(pat_bytes[8*i +: 8]);
      send_text(text);
      settle();
   endtask

   // out-of-range lengths saturate, unused indexes do nothing
   task automatic test_register_limits();
      int n;
      write_reg(sfr_pkg::CSR_PATTERN_BYTES, 64'h51);
      write_reg(sfr_pkg::CSR_PATTERN_LEN, 64'h0);
      write_reg(sfr_pkg::CSR_REPLACEMENT_BYTES, {$urandom, $urandom});
      write_reg(sfr_pkg::CSR_REPLACEMENT_LEN, 64'hF);
      for (n = sfr_pkg::CSR_OUT_LIMIT + 1; n < 8; n++) write_reg(3'(n), {$urandom, $urandom});
      csr_valid <= 1'b0;
      send_word(8'h51, 1'b1);
      settle();
      write_reg(sfr_pkg::CSR_PATTERN_BYTES, 64'h5151_5151_5151_5151);
      write_reg(sfr_pkg::CSR_PATTERN_LEN, 64'h9);
      write_reg(sfr_pkg::CSR_PATTERN_LEN, 64'hF);
      csr_valid <= 1'b0;
      send_word(8'h51, 1'b0);
      send_word(8'h51, 1'b0);
      send_word(8'h51, 1'b1);
      settle();
   endtask

   // zero limit gives a bare end marker, small limit cuts a replacement
   task automatic test_output_limit();
      configure(64'h5A, 1, {$urandom, $urandom}, sfr_pkg::MAX_REPLACEMENT, 0);
      send_word(8'h5A, 1'b0);
      send_word(8'h01, 1'b1);
      settle();
      write_reg(sfr_pkg::CSR_OUT_LIMIT, 64'd3);
      csr_valid <= 1'b0;
      send_word(8'h5A, 1'b1);
      settle();
   endtask

   // pattern length write is dropped while the window holds a byte
   task automatic test_length_write_ignored();
      configure(64'h6261, 2, 64'h52, 1, 65535);
      send_word(8'h61, 1'b0);
      settle();
      write_reg(sfr_pkg::CSR_PATTERN_LEN, 64'h1);
      csr_valid <= 1'b0;
      send_word(8'h62, 1'b1);
      settle();
   endtask

   task automatic test_random_streams();
      byte_queue_type text;
      int             phase;
      int             sent;
      int             phase_sent;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         random_config(phase);
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            text = make_text($urandom_range(1, 16));
            send_text(text);
            phase_sent += text.size();
         end
         settle();
         sent += phase_sent;
         phase++;
      end
   endtask

   // output held off while every match expands to eight words
   task automatic test_backpressure();
      int i;
      configure(64'h5A, 1, {$urandom, $urandom}, sfr_pkg::MAX_REPLACEMENT, 65535);
      hold_output = 1'b1;
      for (i = 0; i < 24; i++) begin
         send_word((i % 2 == 1) ? 8'h5A : 8'($urandom_range(0, 255)), i == 23);
      end
      settle();
   endtask

   // closing stretch with no idling on either side
   task automatic test_steady_flow();
      byte_queue_type text;
      int             sent;
      no_idling = 1'b1;
      random_config(5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         text = make_text($urandom_range(1, 16));
         send_text(text);
         sent += text.size();
      end
      settle();
   endtask

   // result side: random stalls, one long hold on request
   initial begin : receiver
      int held;
      @(negedge clock);
      forever begin
         if (hold_output) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < LONG_HOLD; held++) @(negedge clock);
            hold_output = 1'b0;
         end else if (!no_idling && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // compare each taken result word with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("word with nothing expected, out_byte", rsp_data.out_byte, -1);
         end else begin
            oldest = expected_words.pop_front();
            if (rsp_data.out_byte !== oldest.out_byte)
               report_mismatch("out_byte", rsp_data.out_byte, oldest.out_byte);
            if (rsp_data.out_valid !== oldest.out_valid)
               report_mismatch("out_valid", rsp_data.out_valid, oldest.out_valid);
            if (rsp_data.out_last !== oldest.out_last)
               report_mismatch("out_last", rsp_data.out_last, oldest.out_last);
            if (rsp_data.overflow !== oldest.overflow)
               report_mismatch("overflow", rsp_data.overflow, oldest.overflow);
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_defaults();
      test_matching();
      test_register_limits();
      test_output_limit();
      test_length_write_ignored();
      test_random_streams();
      test_backpressure();
      test_steady_flow();
      if (mismatches == 0) begin
         $display("stream_find_replace_top test passed");
      end else begin
         $display("stream_find_replace_top test failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(RUN_LIMIT_NS);
      $display("run timed out with %0d words outstanding", expected_words.size());
      $display("stream_find_replace_top test failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/sfr_pkg.sv
hdl/sfr_front.sv
hdl/sfr_queue.sv
hdl/sfr_back.sv
hdl/stream_find_replace_top.sv
sim/stream_find_replace_top_tb.sv
